>>> rtl/pcbd_pkg.sv
// ----------------------------------------------------------------------------
// Port-controlled bank decoder package
// Shared types, codes and reset values for the bank decoder block.
// ----------------------------------------------------------------------------
package pcbd_pkg;

   // Width of the configuration register index.
   localparam int CsrIdxW = 2;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_CART_PRESENT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CART_MASK    = 2'd1;

   // Reset values of the configuration and processor port registers.
   localparam logic [15:0] CartMaskReset = 16'h1FFF;
   localparam logic [5:0]  PortDirReset  = 6'b101111;
   localparam logic [5:0]  PortValReset  = 6'b110111;

   // Address masks for the fixed-size regions.
   localparam logic [15:0] VideoMask   = 16'h03FF;
   localparam logic [15:0] RomMask     = 16'h1FFF;
   localparam logic [15:0] ChargenMask = 16'h0FFF;
   localparam logic [15:0] CartHighSet = 16'h1000;

   // Access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Target regions.
   typedef enum logic [3:0] {
      TGT_RAM     = 4'd0,
      TGT_BASIC   = 4'd1,
      TGT_KERNAL  = 4'd2,
      TGT_CHARGEN = 4'd3,
      TGT_CART    = 4'd4,
      TGT_VIDEO   = 4'd5,
      TGT_SOUND   = 4'd6,
      TGT_COLOUR  = 4'd7,
      TGT_CIA1    = 4'd8,
      TGT_CIA2    = 4'd9,
      TGT_IO1     = 4'd10,
      TGT_IO2     = 4'd11,
      TGT_PORT    = 4'd12
   } target_type;

   // Mapping state seen by the decoder.
   typedef struct packed {
      logic        cart_present;
      logic [15:0] cart_addr_mask;
      logic [5:0]  port_direction;
      logic [5:0]  port_value;
   } map_state_type;

   // Processor port update requested by a decoded write.
   typedef struct packed {
      logic       dir_we;
      logic       val_we;
      logic [5:0] data;
   } port_wr_type;

endpackage

>>> rtl/pcbd_if.sv
// ----------------------------------------------------------------------------
// Bank decoder channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Bus access request channel.
interface pcbd_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   output ready);
endinterface

// Decode result channel.
interface pcbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  target;
   logic [15:0] local_addr;
   logic [7:0]  port_data;

   modport source (output valid, output target, output local_addr, output port_data,
                   input ready);
   modport sink   (input valid, input target, input local_addr, input port_data,
                   output ready);
endinterface

// Configuration write channel.
interface pcbd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pcbd_pkg::CsrIdxW-1:0] index;
   logic [15:0]                  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pcbd_state.sv
// ----------------------------------------------------------------------------
// Bank decoder mapping state
// Holds the cartridge configuration registers and the processor port.
// ----------------------------------------------------------------------------
module pcbd_state (
   input  logic                    clock,
   input  logic                    reset,
   pcbd_csr_if.sink                csr_bus,
   input  pcbd_pkg::port_wr_type   port_wr,
   output pcbd_pkg::map_state_type map_state
);

   logic        cart_present_ff, cart_present_in;
   logic [15:0] cart_mask_ff, cart_mask_in;
   logic [5:0]  port_dir_ff, port_dir_in;
   logic [5:0]  port_val_ff, port_val_in;

   // Configuration writes are always taken.
   assign csr_bus.ready = 1'b1;

   // Configuration register next values; unknown indexes are ignored.
   always_comb begin
      cart_present_in = cart_present_ff;
      cart_mask_in    = cart_mask_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            pcbd_pkg::CSR_CART_PRESENT: cart_present_in = csr_bus.data[0];
            pcbd_pkg::CSR_CART_MASK:    cart_mask_in    = csr_bus.data;
            default: ;
         endcase
      end
   end

   // Port writes: direction is replaced, value bits change only where the
   // direction marks them as outputs.
   always_comb begin
      port_dir_in = port_dir_ff;
      port_val_in = port_val_ff;
      if (port_wr.dir_we) begin
         port_dir_in = port_wr.data;
      end
      if (port_wr.val_we) begin
         port_val_in = (port_val_ff & ~port_dir_ff) | (port_wr.data & port_dir_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_present_ff <= 1'b0;
         cart_mask_ff    <= pcbd_pkg::CartMaskReset;
         port_dir_ff     <= pcbd_pkg::PortDirReset;
         port_val_ff     <= pcbd_pkg::PortValReset;
      end else begin
         cart_present_ff <= cart_present_in;
         cart_mask_ff    <= cart_mask_in;
         port_dir_ff     <= port_dir_in;
         port_val_ff     <= port_val_in;
      end
   end

   assign map_state.cart_present   = cart_present_ff;
   assign map_state.cart_addr_mask = cart_mask_ff;
   assign map_state.port_direction = port_dir_ff;
   assign map_state.port_value     = port_val_ff;

endmodule

>>> rtl/pcbd_decode.sv
// ----------------------------------------------------------------------------
// Bank decoder address map
// Combinational decode of one access into target, offset and port data.
// ----------------------------------------------------------------------------
module pcbd_decode (
   input  logic                    operation,
   input  logic [15:0]             address,
   input  logic [7:0]              write_data,
   input  pcbd_pkg::map_state_type map_state,
   output pcbd_pkg::target_type    target,
   output logic [15:0]             local_addr,
   output logic [7:0]              port_data,
   output pcbd_pkg::port_wr_type   port_wr
);

   logic [1:0]             bank_bits;
   logic                   io_on;
   logic                   is_port;
   logic                   in_cart_low;
   logic                   in_basic;
   logic                   in_io;
   logic                   in_kernal;
   logic [15:0]            cart_low_addr;
   logic [15:0]            cart_high_addr;
   pcbd_pkg::target_type   io_target;
   logic [15:0]            io_addr;

   // Region and mapping qualifiers.
   assign bank_bits   = map_state.port_value[1:0];
   assign io_on       = (bank_bits != 2'b00) && map_state.port_value[2];
   assign is_port     = (address[15:1] == 15'd0);
   assign in_cart_low = (address[15:13] == 3'b100);
   assign in_basic    = (address[15:13] == 3'b101);
   assign in_io       = (address[15:12] == 4'hD);
   assign in_kernal   = (address[15:13] == 3'b111);

   assign cart_low_addr  = address & map_state.cart_addr_mask;
   assign cart_high_addr = (address | pcbd_pkg::CartHighSet) & map_state.cart_addr_mask;

   // I/O window split per 256-byte page.
   always_comb begin
      io_addr = address;
      unique case (address[11:8])
         4'h0, 4'h1, 4'h2, 4'h3: begin
            io_target = pcbd_pkg::TGT_VIDEO;
            io_addr   = address & pcbd_pkg::VideoMask;
         end
         4'h4, 4'h5, 4'h6, 4'h7: io_target = pcbd_pkg::TGT_SOUND;
         4'h8, 4'h9, 4'hA, 4'hB: io_target = pcbd_pkg::TGT_COLOUR;
         4'hC:                   io_target = pcbd_pkg::TGT_CIA1;
         4'hD:                   io_target = pcbd_pkg::TGT_CIA2;
         4'hE:                   io_target = pcbd_pkg::TGT_IO1;
         default:                io_target = pcbd_pkg::TGT_IO2;
      endcase
   end

   // Main map. Writes only reach I/O, else RAM; reads may also hit the port, ROMs or cartridge.
   always_comb begin
      target     = pcbd_pkg::TGT_RAM;
      local_addr = address;
      port_data  = 8'd0;
      if (operation == pcbd_pkg::OP_WRITE) begin
         if (in_io && io_on) begin
            target     = io_target;
            local_addr = io_addr;
         end
      end else if (is_port) begin
         target    = pcbd_pkg::TGT_PORT;
         port_data = {2'b00, address[0] ? map_state.port_value : map_state.port_direction};
      end else if (in_cart_low) begin
         if (map_state.cart_present) begin
            target     = pcbd_pkg::TGT_CART;
            local_addr = cart_low_addr;
         end
      end else if (in_basic) begin
         if (bank_bits == 2'b11) begin
            if (map_state.cart_present) begin
               target     = pcbd_pkg::TGT_CART;
               local_addr = cart_high_addr;
            end else begin
               target     = pcbd_pkg::TGT_BASIC;
               local_addr = address & pcbd_pkg::RomMask;
            end
         end
      end else if (in_io) begin
         if (io_on) begin
            target     = io_target;
            local_addr = io_addr;
         end else if (bank_bits != 2'b00) begin
            target     = pcbd_pkg::TGT_CHARGEN;
            local_addr = address & pcbd_pkg::ChargenMask;
         end
      end else if (in_kernal) begin
         if (bank_bits[1]) begin
            if (map_state.cart_present) begin
               target     = pcbd_pkg::TGT_CART;
               local_addr = cart_high_addr;
            end else begin
               target     = pcbd_pkg::TGT_KERNAL;
               local_addr = address & pcbd_pkg::RomMask;
            end
         end
      end
   end

   // Port register update request; the caller qualifies it with the handshake.
   assign port_wr.dir_we = (operation == pcbd_pkg::OP_WRITE) && is_port && !address[0];
   assign port_wr.val_we = (operation == pcbd_pkg::OP_WRITE) && is_port && address[0];
   assign port_wr.data   = write_data[5:0];

endmodule

>>> rtl/port_controlled_bank_decoder_top.sv
// ----------------------------------------------------------------------------
// Port-controlled bank decoder
// Maps each bus access to a target region and offset under processor port
// and cartridge control.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one bus access per item (operation, address, write_data).
//   rsp_bus returns one item per access: target, local_addr and port_data.
//   csr_bus writes cart_present (index 0) and cart_addr_mask (index 1); it is
//   always ready and should only be written while no access is in flight.
// Path: an accepted request is held in the input register, decoded there and
//   then held in the result register until rsp_bus takes it.
// Throughput: one item per cycle while rsp_bus.ready stays high; the decode is a
//   single pass of shallow logic between the two registers and the port
//   update lands in the same cycle, so the next access already sees it.
// Stalls: when rsp_bus.ready is low the result register holds and the input
//   register still takes one more item; further requests wait on
//   req_bus.ready.
// Reset: synchronous, active high. Both pipeline registers empty, port
//   direction 0x2F, port value 0x37, no cartridge, cartridge mask 0x1FFF.
// ----------------------------------------------------------------------------
module port_controlled_bank_decoder_top (
   input  logic      clock,
   input  logic      reset,
   pcbd_req_if.sink   req_bus,
   pcbd_rsp_if.source rsp_bus,
   pcbd_csr_if.sink   csr_bus
);

   logic                    in_valid_ff, in_valid_in;
   logic                    in_op_ff;
   logic [15:0]             in_addr_ff;
   logic [7:0]              in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [3:0]              out_target_ff;
   logic [15:0]             out_addr_ff;
   logic [7:0]              out_pdata_ff;
   logic                    out_load;
   logic                    dec_fire;
   logic                    req_take;
   pcbd_pkg::map_state_type map_state;
   pcbd_pkg::port_wr_type   dec_port_wr;
   pcbd_pkg::port_wr_type   port_wr;
   pcbd_pkg::target_type    dec_target;
   logic [15:0]             dec_addr;
   logic [7:0]              dec_pdata;

   // Pipeline flow control.
   assign out_load      = !out_valid_ff || rsp_bus.ready;
   assign dec_fire      = in_valid_ff && out_load;
   assign req_bus.ready = !in_valid_ff || out_load;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = dec_fire || (out_valid_ff && !rsp_bus.ready);

   // Mapping state: configuration registers and processor port.
   pcbd_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .port_wr   (port_wr),
      .map_state (map_state)
   );

   // Address decode of the item in the input register.
   pcbd_decode u_decode (
      .operation  (in_op_ff),
      .address    (in_addr_ff),
      .write_data (in_data_ff),
      .map_state  (map_state),
      .target     (dec_target),
      .local_addr (dec_addr),
      .port_data  (dec_pdata),
      .port_wr    (dec_port_wr)
   );

   // Port updates commit only when the item moves to the result register.
   assign port_wr.dir_we = dec_port_wr.dir_we && dec_fire;
   assign port_wr.val_we = dec_port_wr.val_we && dec_fire;
   assign port_wr.data   = dec_port_wr.data;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_bus.operation;
         in_addr_ff <= req_bus.address;
         in_data_ff <= req_bus.write_data;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (dec_fire) begin
         out_target_ff <= dec_target;
         out_addr_ff   <= dec_addr;
         out_pdata_ff  <= dec_pdata;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.target     = out_target_ff;
   assign rsp_bus.local_addr = out_addr_ff;
   assign rsp_bus.port_data  = out_pdata_ff;

   // A port result only comes from address 0 or 1.
   a_port_addr : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_target_ff == pcbd_pkg::TGT_PORT) |-> (out_addr_ff[15:1] == 15'd0))
      else $error("port target with address above 1");

   // Port data is zero unless the processor port was read.
   a_pdata_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_target_ff != pcbd_pkg::TGT_PORT) |-> (out_pdata_ff == 8'd0))
      else $error("port data set on a non-port result");

   // Video offsets stay inside the 1 KB register window.
   a_video_mask : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_target_ff == pcbd_pkg::TGT_VIDEO) |-> (out_addr_ff[15:10] == 6'd0))
      else $error("video offset outside its window");

   // The port value only changes after a committed write to address 1.
   a_port_stable : assert property (@(posedge clock) disable iff (reset)
      !port_wr.val_we |=> $stable(map_state.port_value))
      else $error("port value changed without a port write");

   // A stalled result is held in the result register, not lost.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff)
      else $error("stalled result lost");

endmodule

>>> tb/sv/port_controlled_bank_decoder_top_test.sv
// ----------------------------------------------------------------------------
// Bank decoder testbench
// Drives bus accesses and cartridge settings into the port-controlled bank
// decoder and checks every decoded item against a behavioral decode that
// tracks the processor port and cartridge registers on its own.
// ----------------------------------------------------------------------------
module port_controlled_bank_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomPerPhase = 67;
   localparam int PhaseCount     = 6;

   // One decoded item as the block should return it.
   typedef struct {
      pcbd_pkg::target_type target;
      logic [15:0]          local_addr;
      logic [7:0]           port_data;
   } bank_decode_type;

   // Tracks port and cartridge state, predicts decodes and checks results.
   class bank_decode_scoreboard_type;
      logic            cart_present;
      logic [15:0]     cart_addr_mask;
      logic [5:0]      port_dir;
      logic [5:0]      port_val;
      bank_decode_type pending_decodes[$];
      int              mismatches;
      int              accesses;
      int              port_writes;
      int              target_hits[13];

      function new();
         cart_present   = 1'b0;
         cart_addr_mask = pcbd_pkg::CartMaskReset;
         port_dir       = pcbd_pkg::PortDirReset;
         port_val       = pcbd_pkg::PortValReset;
         mismatches     = 0;
         accesses       = 0;
         port_writes    = 0;
         foreach (target_hits[i]) target_hits[i] = 0;
      endfunction

      function void set_register(logic [pcbd_pkg::CsrIdxW-1:0] index, logic [15:0] value);
         case (index)
            pcbd_pkg::CSR_CART_PRESENT: cart_present = value[0];
            pcbd_pkg::CSR_CART_MASK:    cart_addr_mask = value;
            default: ;
         endcase
      endfunction

      // The I/O window is split per 256-byte page.
      function void decode_io(logic [15:0] a, output pcbd_pkg::target_type t,
                              output logic [15:0] loc);
         loc = a;
         case (a[11:8])
            4'h0, 4'h1, 4'h2, 4'h3: begin
               t   = pcbd_pkg::TGT_VIDEO;
               loc = a & pcbd_pkg::VideoMask;
            end
            4'h4, 4'h5, 4'h6, 4'h7: t = pcbd_pkg::TGT_SOUND;
            4'h8, 4'h9, 4'hA, 4'hB: t = pcbd_pkg::TGT_COLOUR;
            4'hC:    t = pcbd_pkg::TGT_CIA1;
            4'hD:    t = pcbd_pkg::TGT_CIA2;
            4'hE:    t = pcbd_pkg::TGT_IO1;
            default: t = pcbd_pkg::TGT_IO2;
         endcase
      endfunction

      // Decodes one access under the current state and applies port writes.
      function bank_decode_type decode_access(logic op, logic [15:0] a, logic [7:0] d);
         bank_decode_type r;
         logic [1:0]      b;
         logic            io_on;
         r.target     = pcbd_pkg::TGT_RAM;
         r.local_addr = a;
         r.port_data  = 8'h00;
         b            = port_val[1:0];
         io_on        = (b != 2'd0) && port_val[2];
         if (op == pcbd_pkg::OP_WRITE) begin
            if (a[15:12] == 4'hD && io_on) decode_io(a, r.target, r.local_addr);
            if (a == 16'h0000) begin
               port_dir = d[5:0];
            end else if (a == 16'h0001) begin
               port_val = (port_val & ~port_dir) | (d[5:0] & port_dir);
            end
         end else if (a <= 16'h0001) begin
            r.target    = pcbd_pkg::TGT_PORT;
            r.port_data = {2'b00, a[0] ? port_val : port_dir};
         end else if (a[15:13] == 3'b100) begin
            if (cart_present) begin
               r.target     = pcbd_pkg::TGT_CART;
               r.local_addr = a & cart_addr_mask;
            end
         end else if (a[15:13] == 3'b101) begin
            if (b == 2'd3) begin
               if (cart_present) begin
                  r.target     = pcbd_pkg::TGT_CART;
                  r.local_addr = (a | pcbd_pkg::CartHighSet) & cart_addr_mask;
               end else begin
                  r.target     = pcbd_pkg::TGT_BASIC;
                  r.local_addr = a & pcbd_pkg::RomMask;
               end
            end
         end else if (a[15:12] == 4'hD) begin
            if (b != 2'd0) begin
               if (port_val[2]) begin
                  decode_io(a, r.target, r.local_addr);
               end else begin
                  r.target     = pcbd_pkg::TGT_CHARGEN;
                  r.local_addr = a & pcbd_pkg::ChargenMask;
               end
            end
         end else if (a[15:13] == 3'b111) begin
            if (b >= 2'd2) begin
               if (cart_present) begin
                  r.target     = pcbd_pkg::TGT_CART;
                  r.local_addr = (a | pcbd_pkg::CartHighSet) & cart_addr_mask;
               end else begin
                  r.target     = pcbd_pkg::TGT_KERNAL;
                  r.local_addr = a & pcbd_pkg::RomMask;
               end
            end
         end
         return r;
      endfunction

      function void note_access(logic op, logic [15:0] a, logic [7:0] d);
         pending_decodes.push_back(decode_access(op, a, d));
         accesses++;
         if (op == pcbd_pkg::OP_WRITE && a <= 16'h0001) port_writes++;
      endfunction

      function int outstanding();
         return pending_decodes.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // Compares one returned item with the oldest prediction.
      task check_result(logic [3:0] t, logic [15:0] loc, logic [7:0] pd);
         bank_decode_type e;
         if (pending_decodes.size() == 0) begin
            report($sformatf("result target %0d addr %h with no access pending", t, loc));
            return;
         end
         e = pending_decodes.pop_front();
         target_hits[e.target]++;
         if (t !== e.target)
            report($sformatf("target %0d, expected %0d (%s)", t, e.target, e.target.name()));
         if (loc !== e.local_addr)
            report($sformatf("local_addr %h, expected %h (%s)", loc, e.local_addr,
                             e.target.name()));
         if (pd !== e.port_data)
            report($sformatf("port_data %h, expected %h", pd, e.port_data));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   req_idle = 1'b1;
   bit   rsp_idle = 1'b1;
   int   rsp_hold_cycles = 0;
   bank_decode_scoreboard_type sb = new();

   pcbd_req_if req_bus();
   pcbd_rsp_if rsp_bus();
   pcbd_csr_if csr_bus();

   port_controlled_bank_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // Offers one access, with an optional gap first, and waits for acceptance.
   task automatic send_access(input logic op, input logic [15:0] a, input logic [7:0] d);
      int gap;
      gap = req_idle ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.address    <= a;
      req_bus.write_data <= d;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_access(op, a, d);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [pcbd_pkg::CsrIdxW-1:0] index,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.set_register(index, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Random access, weighted toward port writes and the banked windows.
   task automatic pick_access(output logic op, output logic [15:0] a, output logic [7:0] d);
      int kind;
      kind = $urandom_range(0, 99);
      op   = 1'($urandom);
      a    = 16'($urandom);
      d    = 8'($urandom);
      if (kind < 8) begin
         op = pcbd_pkg::OP_WRITE;
         a  = 16'h0000;
         if ($urandom_range(0, 1)) d = {2'($urandom), 6'h3F};
      end else if (kind < 22) begin
         op = pcbd_pkg::OP_WRITE;
         a  = 16'h0001;
      end else if (kind < 30) begin
         op = pcbd_pkg::OP_READ;
         a  = 16'($urandom_range(0, 1));
      end else if (kind < 55) begin
         a = {4'hD, 12'($urandom)};
      end else if (kind < 82) begin
         a = 16'($urandom_range(16'h8000, 16'hFFFF));
      end
   endtask

   // Edge addresses under the reset mapping, then the character ROM, kernal and all-RAM port modes.
   task automatic run_directed();
      send_access(pcbd_pkg::OP_READ,  16'h0000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'h0001, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'h0002, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'h7FFF, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'h8000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hBFFF, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hE000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hD000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hD7FF, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hD800, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hDC00, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hDDFF, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hDE00, 8'h00);
      send_access(pcbd_pkg::OP_WRITE, 16'hDFFF, 8'hFF);
      // Open all port bits, then turn the I/O window into character ROM.
      send_access(pcbd_pkg::OP_WRITE, 16'h0000, 8'hFF);
      send_access(pcbd_pkg::OP_WRITE, 16'h0001, 8'hFB);
      send_access(pcbd_pkg::OP_READ,  16'hD123, 8'h00);
      send_access(pcbd_pkg::OP_WRITE, 16'hD400, 8'h55);
      // Kernal and character ROM only, then everything banked out to RAM.
      send_access(pcbd_pkg::OP_WRITE, 16'h0001, 8'h02);
      send_access(pcbd_pkg::OP_READ,  16'hA000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hFFFF, 8'h00);
      send_access(pcbd_pkg::OP_WRITE, 16'h0001, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hD000, 8'h00);
      send_access(pcbd_pkg::OP_READ,  16'hFFFF, 8'h00);
      send_access(pcbd_pkg::OP_WRITE, 16'h0001, 8'hC7);
   endtask

   // Result side: a random stall per item, and a long hold-off on request.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 5) : 0;
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         sb.check_result(rsp_bus.target, rsp_bus.local_addr, rsp_bus.port_data);
      end
   end

   // Stimulus: one cartridge setting per phase, directed items first.
   initial begin
      logic        op;
      logic [15:0] a;
      logic [7:0]  d;
      logic        cart;
      logic [15:0] mask;
      int          reached;
      req_bus.valid      = 1'b0;
      req_bus.operation  = pcbd_pkg::OP_READ;
      req_bus.address    = 16'h0000;
      req_bus.write_data = 8'h00;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = pcbd_pkg::CSR_CART_PRESENT;
      csr_bus.data       = 16'h0000;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         drain();
         case (phase)
            0:       begin cart = 1'b0; mask = pcbd_pkg::CartMaskReset; end
            1:       begin cart = 1'b1; mask = pcbd_pkg::CartMaskReset; end
            2:       begin cart = 1'b1; mask = 16'hFFFF; end
            3:       begin cart = 1'b1; mask = 16'h0000; end
            4:       begin cart = 1'b0; mask = 16'($urandom); end
            default: begin cart = 1'b1; mask = 16'($urandom); end
         endcase
         write_register(pcbd_pkg::CSR_CART_PRESENT, {15'd0, cart});
         write_register(pcbd_pkg::CSR_CART_MASK, mask);
         // Back-to-back in phase 2; one side idles alone in phases 3 and 4.
         req_idle = (phase != 2) && (phase != 3);
         rsp_idle = (phase != 2) && (phase != 4);
         if (phase == 0) run_directed();
         for (int n = 0; n < RandomPerPhase; n++) begin
            if (phase == 1 && n == 20) rsp_hold_cycles = 40;
            if (phase == 5 && n == RandomPerPhase / 2) begin
               end_burst();
               drain();
            end
            pick_access(op, a, d);
            send_access(op, a, d);
         end
         end_burst();
      end
      drain();
      repeat (8) @(posedge clock);

      reached = 0;
      foreach (sb.target_hits[i]) if (sb.target_hits[i] > 0) reached++;
      $display("Decoded %0d accesses (%0d port writes) over %0d cartridge settings.",
               sb.accesses, sb.port_writes, PhaseCount);
      $display("%0d of 13 target regions reached, %0d mismatches.", reached, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_400_000;
      $display("Timeout with %0d decodes still outstanding.", sb.outstanding());
      $display("== FAIL ==");
      $finish;
   end

endmodule
